// ----- hdl/sparse_candidate_accumulator_defines.svh -----
// Assertion helpers used by the block's top RTL file.
// Both sample on clk and are disabled while rst_n is low.
`ifndef SPARSE_CANDIDATE_ACCUMULATOR_DEFINES_SVH
`define SPARSE_CANDIDATE_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication.
`define SCA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sca_pkg.sv -----
`default_nettype none

package sca_pkg;

    localparam int VALUE_BITS = 16;
    localparam int ROW_W      = 10;
    localparam int SUM_W      = 32;
    // product of two Q1.15 values is Q2.30 already
    localparam int Q_SHIFT    = SUM_W - 2 * VALUE_BITS;

    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef struct packed {
        logic                         req_type;
        logic [ROW_W-1:0]             query_row;
        logic [ROW_W-1:0]             cand_row;
        logic signed [VALUE_BITS-1:0] query_value;
        logic signed [VALUE_BITS-1:0] index_value;
    } req_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]        result_row;
        logic signed [SUM_W-1:0] similarity;
        logic                    keep;
        logic                    last;
        logic                    empty_res;
        logic                    overflowed;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_SLOT,
        ST_DRAIN
    } state_t;

    // clamp a sum with one guard bit to the signed SUM_W range
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] x);
        logic signed [SUM_W-1:0] res;
        if (x[SUM_W] != x[SUM_W-1])
            res = x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            res = x[SUM_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sca_stream_if.sv -----
`default_nettype none

interface sca_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/sparse_candidate_accumulator.sv -----
// Sparse candidate accumulator. Each req item is either a product term
// (req_type 0) or a drain request (req_type 1). A term whose cand_row is
// below query_row and NUM_ROWS adds query_value * index_value (Q1.15 x Q1.15 -> Q2.30,
// saturating) into the slot of its candidate row, opening a new slot in
// insertion order on the first term for that row; with all MAX_SLOTS slots in
// use such a term is dropped and the sticky overflowed flag is set. A drain
// returns one res item: the next slot's row and similarity, keep when the
// similarity reaches min_similarity, last on the final slot, or empty_res
// when nothing is left. One item is worked at a time. A counted term passes
// through a marker read, then the dependent slot read, then the slot write;
// an ignored term leaves the block idle, and a drain holds in ST_DRAIN while
// the res output register stays full. The marker table needs no clearing
// pass after reset: a marker counts only when it points into the live slot
// range and that slot records the same row.
`default_nettype none
`include "sparse_candidate_accumulator_defines.svh"

module sparse_candidate_accumulator
    import sca_pkg::*;
#(
    parameter int NUM_ROWS  = 1024,
    parameter int MAX_SLOTS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [SUM_W-1:0]   cfg_wr_data,
    sca_stream_if.sink              req,
    sca_stream_if.source            res
);

    localparam int ROW_AW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int SLOT_DW = ROW_W + SUM_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        dp_reg, dp_next;
    logic                    ovf_reg, ovf_next;
    logic signed [SUM_W-1:0] min_sim_reg;
    logic [ROW_W-1:0]        crow_reg;
    logic                    out_valid_reg, out_valid_next;
    rsp_item_t               out_item_reg, out_item_next;

    logic                    accept;
    logic                    term_ok;
    logic                    out_free;
    logic                    hit;
    logic                    mac_load;

    // marker table: row -> slot index
    logic                    mark_we;
    logic [ROW_AW-1:0]       mark_waddr;
    logic [SLOT_AW-1:0]      mark_wdata;
    logic [ROW_AW-1:0]       mark_raddr;
    logic [SLOT_AW-1:0]      mark_rd;

    // slot table: {row, sum} per slot
    logic                    slot_we;
    logic [SLOT_AW-1:0]      slot_waddr;
    logic [SLOT_DW-1:0]      slot_wdata;
    logic [SLOT_AW-1:0]      slot_raddr;
    logic [SLOT_DW-1:0]      slot_rd;
    logic [ROW_W-1:0]        slot_rd_row;
    logic signed [SUM_W-1:0] slot_rd_sum;

    logic signed [SUM_W-1:0] mac_sum;
    logic signed [SUM_W-1:0] mac_first;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || res.ready;
    assign term_ok  = (req.data.req_type == REQ_ACCUM)
                   && (req.data.cand_row < req.data.query_row)
                   && (32'(req.data.cand_row) < 32'(NUM_ROWS));
    assign mac_load = accept;

    assign req.ready = (state_reg == ST_IDLE);
    assign res.valid = out_valid_reg;
    assign res.data  = out_item_reg;

    assign slot_rd_row = slot_rd[SLOT_DW-1:SUM_W];
    assign slot_rd_sum = slot_rd[SUM_W-1:0];

    // a marker is live only inside [drain position, slot count) and when
    // that slot still belongs to the same row
    assign hit = (CNT_W'(mark_rd) < count_reg)
              && (CNT_W'(mark_rd) >= dp_reg)
              && (slot_rd_row == crow_reg);

    // read addresses: marker by incoming row while idle, held row afterwards; slot by marker or drain position
    assign mark_raddr = (state_reg == ST_IDLE) ? ROW_AW'(req.data.cand_row)
                                               : ROW_AW'(crow_reg);
    assign slot_raddr = ((state_reg == ST_MARK) || (state_reg == ST_SLOT))
                      ? mark_rd : dp_reg[SLOT_AW-1:0];
    assign mark_waddr = ROW_AW'(crow_reg);

    sca_ram #(
        .DEPTH (NUM_ROWS),
        .WIDTH (SLOT_AW)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rd)
    );

    sca_ram #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (SLOT_DW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rd)
    );

    sca_mac u_mac (
        .clk   (clk),
        .load  (mac_load),
        .a     (req.data.query_value),
        .b     (req.data.index_value),
        .acc   (slot_rd_sum),
        .sum   (mac_sum),
        .first (mac_first)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.data.req_type == REQ_DRAIN)
                        state_next = ST_DRAIN;
                    else if (term_ok)
                        state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                state_next = ST_SLOT;
            end
            ST_SLOT:
            begin
                state_next = ST_IDLE;
            end
            ST_DRAIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // table updates, counters and the result register
    always_comb
    begin
        count_next     = count_reg;
        dp_next        = dp_reg;
        ovf_next       = ovf_reg;
        mark_we        = 1'b0;
        mark_wdata     = count_reg[SLOT_AW-1:0];
        slot_we        = 1'b0;
        slot_waddr     = mark_rd;
        slot_wdata     = {crow_reg, mac_sum};
        out_valid_next = out_valid_reg && !res.ready;
        out_item_next  = out_item_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_MARK:
            begin
            end
            ST_SLOT:
            begin
                if (hit)
                begin
                    // add into the row's open slot
                    slot_we    = 1'b1;
                    slot_waddr = mark_rd;
                    slot_wdata = {crow_reg, mac_sum};
                end
                else if (count_reg < MAX_CNT)
                begin
                    // open a new slot at the tail
                    slot_we    = 1'b1;
                    slot_waddr = count_reg[SLOT_AW-1:0];
                    slot_wdata = {crow_reg, mac_first};
                    mark_we    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    // drop the term
                    ovf_next = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (dp_reg >= count_reg)
                    begin
                        out_item_next           = '0;
                        out_item_next.empty_res = 1'b1;
                        count_next              = '0;
                        dp_next                 = '0;
                    end
                    else
                    begin
                        out_item_next.result_row = slot_rd_row;
                        out_item_next.similarity = slot_rd_sum;
                        out_item_next.keep       = (slot_rd_sum >= min_sim_reg);
                        out_item_next.last       = ((dp_reg + CNT_W'(1)) >= count_reg);
                        out_item_next.empty_res  = 1'b0;
                        out_item_next.overflowed = ovf_reg;
                        if ((dp_reg + CNT_W'(1)) >= count_reg)
                        begin
                            count_next = '0;
                            dp_next    = '0;
                        end
                        else
                        begin
                            dp_next = dp_reg + CNT_W'(1);
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dp_reg        <= '0;
            ovf_reg       <= 1'b0;
            min_sim_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dp_reg        <= dp_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                min_sim_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            crow_reg <= req.data.cand_row;
        end
        out_item_reg <= out_item_next;
    end

    `SCA_ASSERT_IMPLY(a_drain_pos_in_range, 1'b1, dp_reg <= count_reg,
        "drain position passed slot count")
    `SCA_ASSERT_IMPLY(a_count_in_range, 1'b1, count_reg <= MAX_CNT,
        "slot count beyond capacity")
    `SCA_ASSERT_NEXT(a_overflow_sticky, ovf_reg, ovf_reg,
        "overflow flag cleared without reset")
    `SCA_ASSERT_NEXT(a_drain_loads_result, (state_reg == ST_DRAIN) && out_free,
        out_valid_reg && (state_reg == ST_IDLE),
        "drain finished without a result")

endmodule

`default_nettype wire

// ----- hdl/sca_ram.sv -----
`default_nettype none

module sca_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/sca_mac.sv -----
`default_nettype none

module sca_mac
    import sca_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         load,
    input  wire logic signed [VALUE_BITS-1:0] a,
    input  wire logic signed [VALUE_BITS-1:0] b,
    input  wire logic signed [SUM_W-1:0]      acc,
    output logic signed [SUM_W-1:0]           sum,
    output logic signed [SUM_W-1:0]           first
);

    logic signed [2*VALUE_BITS-1:0] prod_reg;
    logic signed [SUM_W-1:0]        prod_q;

    // hold the product of the latest accepted req item
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod_q = SUM_W'(prod_reg) <<< Q_SHIFT;
    assign first  = prod_q;
    assign sum    = sat_sum({acc[SUM_W-1], acc} + {prod_q[SUM_W-1], prod_q});

endmodule

`default_nettype wire
